// File: rtl/core/islx_pkg.sv
package islx_pkg;

	localparam int unsigned MAX_TOKEN_CHARS_DEF = 255;

	// lexer state codes
	localparam logic [4:0] ST_START     = 5'd1;
	localparam logic [4:0] ST_SEC_OPEN  = 5'd2;
	localparam logic [4:0] ST_SEC_NAME  = 5'd3;
	localparam logic [4:0] ST_SEC_TAIL  = 5'd4;
	localparam logic [4:0] ST_SEC_CLOSE = 5'd5;
	localparam logic [4:0] ST_LINE      = 5'd6;
	localparam logic [4:0] ST_KEY       = 5'd7;
	localparam logic [4:0] ST_KEY_TAIL  = 5'd8;
	localparam logic [4:0] ST_EQ        = 5'd9;
	localparam logic [4:0] ST_VALUE     = 5'd10;
	localparam logic [4:0] ST_VAL_END   = 5'd11;
	localparam logic [4:0] ST_VAL_CMT   = 5'd12;
	localparam logic [4:0] ST_CMT_FIRST = 5'd14;
	localparam logic [4:0] ST_CMT       = 5'd15;
	localparam logic [4:0] ST_CMT_END   = 5'd16;
	localparam logic [4:0] ST_SEC_SP    = 5'd17;
	localparam logic [4:0] ST_TOP_CMT   = 5'd18;
	localparam logic [4:0] ST_ERROR     = 5'd31;

	// event codes
	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_SEC_CHAR  = 3'd1;
	localparam logic [2:0] EV_SEC_DONE  = 3'd2;
	localparam logic [2:0] EV_SEC_OPEN  = 3'd3;
	localparam logic [2:0] EV_KEY_CHAR  = 3'd4;
	localparam logic [2:0] EV_KEY_DONE  = 3'd5;
	localparam logic [2:0] EV_VAL_CHAR  = 3'd6;
	localparam logic [2:0] EV_VAL_DONE  = 3'd7;

	// character codes
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_VTAB   = 8'h0B;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LBR    = 8'h5B;
	localparam logic [7:0] CH_RBR    = 8'h5D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DASH   = 8'h2D;

	// one classified byte, as it travels from front to back
	typedef struct packed {
		logic [7:0] chr;
		logic       eot;
		logic       nl;
		logic       space;
		logic       enter;
		logic       name;
		logic       digit;
		logic       value;
		logic       lbr;
		logic       rbr;
		logic       semi;
		logic       eq;
	} islx_item_t;

endpackage

// File: rtl/core/islx_front.sv
module islx_front (
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           text_byte,
	input  logic                 end_of_text,
	output logic                 push,
	output islx_pkg::islx_item_t push_item,
	input  logic                 q_full
);
	import islx_pkg::*;

	logic [7:0] c;
	logic       name_c;
	logic       digit_c;
	logic       drop;

	assign in_ready = !q_full;
	// a bare CR is taken and discarded
	assign drop = !end_of_text && (text_byte == CH_CR);
	assign push = in_valid && in_ready && !drop;

	assign c = end_of_text ? CH_LF : text_byte;

	always_comb begin
		name_c = ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z))
			|| (c == CH_UNDER) || (c == CH_SLASH) || (c == CH_BSLASH);
		digit_c = (c >= CH_ZERO) && (c <= CH_NINE);
		push_item.chr   = c;
		push_item.eot   = end_of_text;
		push_item.nl    = (c == CH_LF);
		push_item.space = (c == CH_SPACE) || (c == CH_VTAB);
		push_item.enter = (c == CH_CR) || (c == CH_LF);
		push_item.name  = name_c;
		push_item.digit = digit_c;
		push_item.value = name_c || digit_c || (c == CH_LPAR) || (c == CH_RPAR)
			|| (c == CH_COMMA) || (c == CH_DOT) || (c == CH_COLON) || (c == CH_DASH);
		push_item.lbr   = (c == CH_LBR);
		push_item.rbr   = (c == CH_RBR);
		push_item.semi  = (c == CH_SEMI);
		push_item.eq    = (c == CH_EQ);
	end

endmodule

// File: rtl/core/islx_queue.sv
module islx_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  islx_pkg::islx_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output islx_pkg::islx_item_t head_item
);
	import islx_pkg::*;

	islx_item_t  mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/core/islx_back.sv
module islx_back #(
	parameter int unsigned MAX_TOKEN_CHARS = islx_pkg::MAX_TOKEN_CHARS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 not_empty,
	input  islx_pkg::islx_item_t head_item,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           event_kind,
	output logic [7:0]           char_out,
	output logic [15:0]          line_number,
	output logic                 error_seen
);
	import islx_pkg::*;

	localparam int unsigned LEN_W = $clog2(MAX_TOKEN_CHARS + 1);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_CHARS);
	localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

	logic [4:0]       state_q;
	logic [LEN_W-1:0] len_q;
	logic [15:0]      line_q;
	logic             err_q;

	logic             out_valid_q;
	logic [2:0]       kind_q;
	logic [7:0]       char_q;
	logic [15:0]      line_out_q;
	logic             err_out_q;

	logic [4:0]       nxt_state;
	logic [LEN_W-1:0] nxt_len;
	logic [15:0]      nxt_line;
	logic             nxt_err;
	logic [2:0]       ev;
	logic [7:0]       ev_ch;
	logic             full_tok;
	islx_item_t       it;

	assign it       = head_item;
	assign pop      = not_empty && (!out_valid_q || out_ready);
	assign full_tok = (len_q >= LEN_MAX);
	assign nxt_line = it.nl ? line_q + 16'd1 : line_q;

	always_comb begin
		nxt_state = state_q;
		nxt_len   = len_q;
		nxt_err   = err_q;
		ev        = EV_NONE;
		ev_ch     = 8'h00;
		unique case (state_q) inside
			ST_START: begin
				if (it.space || it.enter) begin
					nxt_state = ST_START;
				end else if (it.lbr) begin
					nxt_state = ST_SEC_OPEN;
				end else if (it.semi) begin
					nxt_state = ST_TOP_CMT;
				end else begin
					nxt_state = ST_ERROR;
					nxt_err   = 1'b1;
				end
			end
			ST_SEC_OPEN: begin
				if (it.space) begin
					nxt_state = ST_SEC_OPEN;
				end else if (it.name) begin
					nxt_len   = LEN_ONE;
					nxt_state = ST_SEC_NAME;
					ev        = EV_SEC_CHAR;
					ev_ch     = it.chr;
				end else begin
					nxt_state = ST_ERROR;
					nxt_err   = 1'b1;
				end
			end
			ST_SEC_NAME: begin
				if ((it.name || it.digit) && !full_tok) begin
					nxt_len = len_q + LEN_ONE;
					ev      = EV_SEC_CHAR;
					ev_ch   = it.chr;
				end else if (it.space && !it.name) begin
					nxt_state = ST_SEC_TAIL;
					nxt_len   = '0;
					ev        = EV_SEC_DONE;
				end else if (it.rbr) begin
					nxt_state = ST_SEC_CLOSE;
					nxt_len   = '0;
					ev        = EV_SEC_DONE;
				end else begin
					nxt_state = ST_ERROR;
					nxt_err   = 1'b1;
				end
			end
			ST_SEC_TAIL: begin
				if (it.space) begin
					nxt_state = ST_SEC_TAIL;
				end else if (it.rbr) begin
					nxt_state = ST_SEC_CLOSE;
				end else begin
					nxt_state = ST_ERROR;
					nxt_err   = 1'b1;
				end
			end
			ST_SEC_CLOSE: begin
				// section opened is reported even when this byte is an error
				ev = EV_SEC_OPEN;
				if (it.enter) begin
					nxt_state = ST_LINE;
				end else if (it.space) begin
					nxt_state = ST_SEC_SP;
				end else if (it.semi) begin
					nxt_state = ST_CMT_FIRST;
				end else begin
					nxt_state = ST_ERROR;
					nxt_err   = 1'b1;
				end
			end
			ST_LINE, ST_VAL_END, ST_CMT_END: begin
				if (it.space || it.enter) begin
					nxt_state = ST_LINE;
				end else if (it.name) begin
					nxt_len   = LEN_ONE;
					nxt_state = ST_KEY;
					ev        = EV_KEY_CHAR;
					ev_ch     = it.chr;
				end else if (it.semi) begin
					nxt_state = ST_CMT_FIRST;
				end else if (it.lbr) begin
					nxt_state = ST_SEC_OPEN;
				end else begin
					nxt_state = ST_ERROR;
					nxt_err   = 1'b1;
				end
			end
			ST_KEY: begin
				if ((it.name || it.digit) && !full_tok) begin
					nxt_len = len_q + LEN_ONE;
					ev      = EV_KEY_CHAR;
					ev_ch   = it.chr;
				end else if (it.space && !it.name && !it.digit) begin
					nxt_state = ST_KEY_TAIL;
				end else if (it.eq) begin
					nxt_state = ST_EQ;
					nxt_len   = '0;
					ev        = EV_KEY_DONE;
				end else begin
					nxt_state = ST_ERROR;
					nxt_err   = 1'b1;
				end
			end
			ST_KEY_TAIL: begin
				if (it.space) begin
					nxt_state = ST_KEY_TAIL;
				end else if (it.eq) begin
					nxt_state = ST_EQ;
					nxt_len   = '0;
					ev        = EV_KEY_DONE;
				end else begin
					nxt_state = ST_ERROR;
					nxt_err   = 1'b1;
				end
			end
			ST_EQ: begin
				if (it.space) begin
					nxt_state = ST_EQ;
				end else if (it.value) begin
					nxt_len   = LEN_ONE;
					nxt_state = ST_VALUE;
					ev        = EV_VAL_CHAR;
					ev_ch     = it.chr;
				end else begin
					nxt_state = ST_ERROR;
					nxt_err   = 1'b1;
				end
			end
			ST_VALUE: begin
				if ((it.space || it.value) && !full_tok) begin
					nxt_len = len_q + LEN_ONE;
					ev      = EV_VAL_CHAR;
					ev_ch   = it.chr;
				end else if (it.enter) begin
					nxt_state = ST_VAL_END;
					nxt_len   = '0;
					ev        = EV_VAL_DONE;
				end else if (it.semi) begin
					nxt_state = ST_VAL_CMT;
					nxt_len   = '0;
					ev        = EV_VAL_DONE;
				end else begin
					nxt_state = ST_ERROR;
					nxt_err   = 1'b1;
				end
			end
			ST_VAL_CMT, ST_CMT_FIRST, ST_CMT: begin
				nxt_state = it.enter ? ST_CMT_END : ST_CMT;
			end
			ST_SEC_SP: begin
				if (it.space) begin
					nxt_state = ST_SEC_SP;
				end else if (it.enter) begin
					nxt_state = ST_LINE;
				end else if (it.semi) begin
					nxt_state = ST_CMT_FIRST;
				end else begin
					nxt_state = ST_ERROR;
					nxt_err   = 1'b1;
				end
			end
			ST_TOP_CMT: begin
				nxt_state = it.enter ? ST_START : ST_TOP_CMT;
			end
			ST_ERROR: begin
				nxt_err = 1'b1;
			end
			default: begin
				nxt_state = state_q;
			end
		endcase
		// end marker restarts the lexer after the newline is processed
		if (it.eot) begin
			nxt_state = ST_START;
			nxt_len   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_START;
			len_q       <= '0;
			line_q      <= 16'd0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				state_q     <= nxt_state;
				len_q       <= nxt_len;
				line_q      <= nxt_line;
				err_q       <= nxt_err;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q     <= ev;
			char_q     <= ev_ch;
			line_out_q <= nxt_line;
			err_out_q  <= nxt_err;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_kind  = kind_q;
	assign char_out    = char_q;
	assign line_number = line_out_q;
	assign error_seen  = err_out_q;

endmodule

// File: rtl/core/ini_section_key_value_lexer_unit.sv
// Channel   Handshake              Payload
// input     in_valid / in_ready    text_byte[7:0], end_of_text
// output    out_valid / out_ready  event_kind[2:0], char_out[7:0], line_number[15:0], error_seen
//
// One byte per cycle sustained while out_ready is high; results pass the queue, then the output register.
// Front classifies the byte, a two-entry queue feeds the lexer FSM, which writes an
// output register. A bare CR is taken and yields no result.
// Output stalls fill the queue; in_ready drops only when the queue holds two bytes.
// arst_n clears the lexer to its start state, line count and error flag to zero.
module ini_section_key_value_lexer_unit #(
	parameter int unsigned MAX_TOKEN_CHARS = islx_pkg::MAX_TOKEN_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_kind,
	output logic [7:0]  char_out,
	output logic [15:0] line_number,
	output logic        error_seen
);
	import islx_pkg::*;

	logic       push;
	logic       q_full;
	logic       pop;
	logic       not_empty;
	islx_item_t push_item;
	islx_item_t head_item;

	islx_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.push       (push),
		.push_item  (push_item),
		.q_full     (q_full)
	);

	islx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (not_empty),
		.head_item (head_item)
	);

	islx_back #(
		.MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.not_empty  (not_empty),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_kind (event_kind),
		.char_out   (char_out),
		.line_number(line_number),
		.error_seen (error_seen)
	);

endmodule
